[rtl/dbgd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbgd_pkg
// Shared types, register indexes and action codes of the dual button gesture
// detector.
// ----------------------------------------------------------------------------
package dbgd_pkg;

  localparam int TIME_W      = 32;
  localparam int CFG_TIME_W  = 16;
  localparam int ACT_W       = 3;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int RES_DEPTH   = 4;

  localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS = 3'd1;
  localparam logic [2:0] REG_DBL_WINDOW = 3'd2;
  localparam logic [2:0] REG_ARM_REL    = 3'd3;
  localparam logic [2:0] REG_KEY_A_EN   = 3'd4;
  localparam logic [2:0] REG_KEY_B_EN   = 3'd5;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [15:0] LONG_PRESS_RST = 16'd800;
  localparam logic [15:0] DBL_WINDOW_RST = 16'd300;
  localparam logic [15:0] ARM_REL_RST    = 16'd500;

  // Per-key gesture codes; the action code is the key base plus this code.
  localparam logic [1:0] GEST_CLICK  = 2'd0;
  localparam logic [1:0] GEST_LONG   = 2'd1;
  localparam logic [1:0] GEST_DOUBLE = 2'd2;

  localparam logic [2:0] ACT_A_BASE = 3'd0;
  localparam logic [2:0] ACT_B_BASE = 3'd3;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              key_a_pressed;
    logic              key_b_pressed;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic level;
    logic arm;
    logic scan;
  } key_ctrl_t;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] debounce_time;
    logic [CFG_TIME_W-1:0] long_press_time;
    logic [CFG_TIME_W-1:0] double_click_window;
  } key_cfg_t;

  typedef struct packed {
    logic       fire;
    logic [1:0] code;
  } key_res_t;

endpackage

[rtl/dual_button_gesture_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_button_gesture_detector
// Debounces two buttons and reports click, double click and long press
// actions after an arming interval with both keys released.
//
//   Channel   Direction  Handshake        Payload
//   in_       input      in_valid/stall   in_item_t: now_ms, key A, key B
//   out_      output     out_valid/stall  out_item_t: action, last
//   cfg       input      APB psel/penable six registers at 4*i
//
// A sample enters an input register and is evaluated once the result queue has
// room for two results, which updates all key state and queues zero, one or two
// results. One sample per cycle is sustained while the queue has that room; the
// result queue delivers one result per cycle while out_stall is low.
// The input stalls only while the result queue lacks room for two results.
// Reset is synchronous and restores the disarmed state and register defaults.
// ----------------------------------------------------------------------------
module dual_button_gesture_detector import dbgd_pkg::*; #(
  parameter int RES_FIFO_DEPTH = RES_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CFG_TIME_W-1:0] debounce_r, long_press_r, dbl_window_r, arm_rel_r;
  logic                  key_a_en_r, key_b_en_r;
  logic                  cfg_wr;
  logic [2:0]            cfg_idx;

  logic                  in_vld_r, in_vld_nxt;
  in_item_t              in_r;
  logic                  accept;
  logic                  consume;
  logic                  room2;

  logic                  armed_r, armed_nxt;
  logic                  rel_timing_r, rel_timing_nxt;
  logic [TIME_W-1:0]     rel_since_r, rel_since_nxt;
  logic                  arm_go;
  logic                  held_a, held_b;
  logic [TIME_W-1:0]     d_rel;

  key_ctrl_t             ctrl_a, ctrl_b;
  key_cfg_t              key_cfg;
  key_res_t              res_a, res_b;
  logic [1:0]            push_n;
  out_item_t             push_d0, push_d1;
  out_item_t             item_a, item_b;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
      dbl_window_r <= DBL_WINDOW_RST;
      arm_rel_r    <= ARM_REL_RST;
      key_a_en_r   <= 1'b1;
      key_b_en_r   <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEBOUNCE:   debounce_r   <= pwdata[CFG_TIME_W-1:0];
        REG_LONG_PRESS: long_press_r <= pwdata[CFG_TIME_W-1:0];
        REG_DBL_WINDOW: dbl_window_r <= pwdata[CFG_TIME_W-1:0];
        REG_ARM_REL:    arm_rel_r    <= pwdata[CFG_TIME_W-1:0];
        REG_KEY_A_EN:   key_a_en_r   <= pwdata[0];
        REG_KEY_B_EN:   key_b_en_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEBOUNCE:   prdata = {{(CFG_DATA_W-CFG_TIME_W){1'b0}}, debounce_r};
      REG_LONG_PRESS: prdata = {{(CFG_DATA_W-CFG_TIME_W){1'b0}}, long_press_r};
      REG_DBL_WINDOW: prdata = {{(CFG_DATA_W-CFG_TIME_W){1'b0}}, dbl_window_r};
      REG_ARM_REL:    prdata = {{(CFG_DATA_W-CFG_TIME_W){1'b0}}, arm_rel_r};
      REG_KEY_A_EN:   prdata = {{(CFG_DATA_W-1){1'b0}}, key_a_en_r};
      REG_KEY_B_EN:   prdata = {{(CFG_DATA_W-1){1'b0}}, key_b_en_r};
      default:        prdata = '0;
    endcase
  end

  assign consume  = in_vld_r && room2;
  assign in_stall = in_vld_r && !consume;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (consume) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  assign held_a = key_a_en_r && in_r.key_a_pressed;
  assign held_b = key_b_en_r && in_r.key_b_pressed;
  assign d_rel  = in_r.now_ms - rel_since_r;

  always_comb begin
    armed_nxt      = armed_r;
    rel_timing_nxt = rel_timing_r;
    rel_since_nxt  = rel_since_r;
    arm_go         = 1'b0;
    if (consume && !armed_r) begin
      if (held_a || held_b) begin
        rel_timing_nxt = 1'b0;
        rel_since_nxt  = '0;
      end else if (!rel_timing_r) begin
        rel_timing_nxt = 1'b1;
        rel_since_nxt  = in_r.now_ms;
      end else if (d_rel >= {{(TIME_W-CFG_TIME_W){1'b0}}, arm_rel_r}) begin
        arm_go    = 1'b1;
        armed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      rel_timing_r <= 1'b0;
      rel_since_r  <= '0;
    end else begin
      armed_r      <= armed_nxt;
      rel_timing_r <= rel_timing_nxt;
      rel_since_r  <= rel_since_nxt;
    end
  end

  assign key_cfg.debounce_time       = debounce_r;
  assign key_cfg.long_press_time     = long_press_r;
  assign key_cfg.double_click_window = dbl_window_r;

  assign ctrl_a.load  = consume && !armed_r;
  assign ctrl_a.level = held_a;
  assign ctrl_a.arm   = arm_go;
  assign ctrl_a.scan  = consume && (armed_r || arm_go) && key_a_en_r;

  assign ctrl_b.load  = consume && !armed_r;
  assign ctrl_b.level = held_b;
  assign ctrl_b.arm   = arm_go;
  assign ctrl_b.scan  = consume && (armed_r || arm_go) && key_b_en_r;

  dbgd_key u_key_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl_a),
    .cfg     (key_cfg),
    .now_ms  (in_r.now_ms),
    .pressed (in_r.key_a_pressed),
    .res     (res_a)
  );

  dbgd_key u_key_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl_b),
    .cfg     (key_cfg),
    .now_ms  (in_r.now_ms),
    .pressed (in_r.key_b_pressed),
    .res     (res_b)
  );

  assign item_a.action = ACT_A_BASE + {1'b0, res_a.code};
  assign item_b.action = ACT_B_BASE + {1'b0, res_b.code};
  assign item_a.last   = !res_b.fire;
  assign item_b.last   = 1'b1;

  always_comb begin
    push_n  = {1'b0, res_a.fire} + {1'b0, res_b.fire};
    push_d0 = res_a.fire ? item_a : item_b;
    push_d1 = item_b;
  end

  dbgd_res_fifo #(
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_d0   (push_d0),
    .push_d1   (push_d1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/dbgd_key.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbgd_key
// State and gesture logic of one key: debounce, long press, double click and
// single click after the double-click window.
// ----------------------------------------------------------------------------
module dbgd_key import dbgd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  key_ctrl_t         ctrl,
  input  key_cfg_t          cfg,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              pressed,
  output key_res_t          res
);

  logic              raw_r, raw_nxt;
  logic              stable_r, stable_nxt;
  logic              long_rep_r, long_rep_nxt;
  logic [1:0]        clicks_r, clicks_nxt;
  logic [TIME_W-1:0] raw_time_r, raw_time_nxt;
  logic [TIME_W-1:0] press_time_r, press_time_nxt;
  logic [TIME_W-1:0] rel_time_r, rel_time_nxt;

  always_comb begin
    logic [TIME_W-1:0] d_deb;
    logic [TIME_W-1:0] d_long;
    logic [TIME_W-1:0] d_rel;
    d_deb          = '0;
    d_long         = '0;
    d_rel          = '0;
    raw_nxt        = raw_r;
    stable_nxt     = stable_r;
    long_rep_nxt   = long_rep_r;
    clicks_nxt     = clicks_r;
    raw_time_nxt   = raw_time_r;
    press_time_nxt = press_time_r;
    rel_time_nxt   = rel_time_r;
    res            = '0;
    if (ctrl.load) begin
      raw_nxt    = ctrl.level;
      stable_nxt = ctrl.level;
      clicks_nxt = 2'd0;
    end
    if (ctrl.arm) begin
      raw_time_nxt = now_ms;
    end
    if (ctrl.scan) begin
      if (pressed != raw_nxt) begin
        raw_nxt      = pressed;
        raw_time_nxt = now_ms;
      end
      d_deb = now_ms - raw_time_nxt;
      if (d_deb >= {{(TIME_W-CFG_TIME_W){1'b0}}, cfg.debounce_time} &&
          pressed != stable_nxt) begin
        stable_nxt = pressed;
        if (pressed) begin
          press_time_nxt = now_ms;
          long_rep_nxt   = 1'b0;
        end else if (!long_rep_nxt) begin
          clicks_nxt   = clicks_nxt + 2'd1;
          rel_time_nxt = now_ms;
          if (clicks_nxt >= 2'd2) begin
            res.fire   = 1'b1;
            res.code   = GEST_DOUBLE;
            clicks_nxt = 2'd0;
          end
        end
      end
      d_long = now_ms - press_time_nxt;
      if (stable_nxt && !long_rep_nxt &&
          d_long >= {{(TIME_W-CFG_TIME_W){1'b0}}, cfg.long_press_time}) begin
        long_rep_nxt = 1'b1;
        clicks_nxt   = 2'd0;
        res.fire     = 1'b1;
        res.code     = GEST_LONG;
      end
      d_rel = now_ms - rel_time_nxt;
      if (!stable_nxt && clicks_nxt == 2'd1 &&
          d_rel >= {{(TIME_W-CFG_TIME_W){1'b0}}, cfg.double_click_window}) begin
        res.fire   = 1'b1;
        res.code   = GEST_CLICK;
        clicks_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r        <= 1'b0;
      stable_r     <= 1'b0;
      long_rep_r   <= 1'b0;
      clicks_r     <= 2'd0;
      raw_time_r   <= '0;
      press_time_r <= '0;
      rel_time_r   <= '0;
    end else begin
      raw_r        <= raw_nxt;
      stable_r     <= stable_nxt;
      long_rep_r   <= long_rep_nxt;
      clicks_r     <= clicks_nxt;
      raw_time_r   <= raw_time_nxt;
      press_time_r <= press_time_nxt;
      rel_time_r   <= rel_time_nxt;
    end
  end

endmodule

[rtl/dbgd_res_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbgd_res_fifo
// Result queue that takes up to two results per cycle and delivers one per
// cycle on the output channel while out_stall is low.
// ----------------------------------------------------------------------------
module dbgd_res_fifo import dbgd_pkg::*; #(
  parameter int DEPTH = RES_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [1:0] push_n,
  input  out_item_t push_d0,
  input  out_item_t push_d1,
  output logic      room2,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t         mem_r [DEPTH];
  logic [PW-1:0]     wr_r, wr_nxt, wr1;
  logic [PW-1:0]     rd_r, rd_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;
  assign room2     = (cnt_r <= CW'(DEPTH - 2));
  assign wr1       = ptr_inc(wr_r);

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r + CW'(push_n) - CW'(pop);
    if (push_n == 2'd1) begin
      wr_nxt = wr1;
    end else if (push_n == 2'd2) begin
      wr_nxt = ptr_inc(wr1);
    end
    if (pop) begin
      rd_nxt = ptr_inc(rd_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= push_d0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr1] <= push_d1;
    end
  end

endmodule

[tb/sv/tb_dual_button_gesture_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_button_gesture_detector
// Self-checking testbench for the dual button gesture detector. A short table
// of samples arms the block and walks through a click, a double click and
// long presses. Random button gestures with contact bounce and noise follow,
// under several register settings and idling patterns. Every result
// transaction is checked against table entries or an in-line gesture model.
// ----------------------------------------------------------------------------
module tb_dual_button_gesture_detector;
  import dbgd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_SAMPLES = 135;
  localparam int NUM_PHASES    = 8;
  localparam int DIR_ROWS      = 25;
  localparam int PRINT_LIMIT   = 100;

  localparam logic [2:0] A_CLICK  = ACT_A_BASE + {1'b0, GEST_CLICK};
  localparam logic [2:0] A_LONG   = ACT_A_BASE + {1'b0, GEST_LONG};
  localparam logic [2:0] A_DOUBLE = ACT_A_BASE + {1'b0, GEST_DOUBLE};
  localparam logic [2:0] B_LONG   = ACT_B_BASE + {1'b0, GEST_LONG};
  localparam logic [2:0] NO_ACT   = ACT_A_BASE;
  localparam logic [2:0] REG_SPARE = REG_KEY_B_EN + 3'd1;

  typedef struct {
    logic [31:0] at_ms;
    logic        a;
    logic        b;
    bit          typed;
    int          n;
    logic [2:0]  act0;
    logic [2:0]  act1;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic [15:0] cfg_debounce;
  logic [15:0] cfg_long;
  logic [15:0] cfg_window;
  logic [15:0] cfg_arm;
  logic        cfg_en_a;
  logic        cfg_en_b;

  logic        lvl_raw[2];
  logic        lvl_stable[2];
  logic        long_seen[2];
  logic [1:0]  click_cnt[2];
  logic [31:0] t_raw_edge[2];
  logic [31:0] t_press[2];
  logic [31:0] t_release[2];
  logic        is_armed;
  logic        quiet_timing;
  logic [31:0] quiet_since;

  out_item_t   expected_gestures[$];
  dir_row_t    dir_tab[DIR_ROWS];
  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic [31:0] t_now;
  logic        hold_a;
  logic        hold_b;

  dual_button_gesture_detector dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_LIMIT) begin
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    end
    mismatches++;
  endtask

  task automatic classify_key(input int k, input logic [31:0] now, input logic pressed,
                              output logic fire, output logic [1:0] code);
    logic [31:0] elapsed;
    fire = 1'b0;
    code = GEST_CLICK;
    if (pressed != lvl_raw[k]) begin
      lvl_raw[k] = pressed;
      t_raw_edge[k] = now;
    end
    elapsed = now - t_raw_edge[k];
    if (elapsed >= {16'd0, cfg_debounce} && pressed != lvl_stable[k]) begin
      lvl_stable[k] = pressed;
      if (pressed) begin
        t_press[k] = now;
        long_seen[k] = 1'b0;
      end else if (!long_seen[k]) begin
        click_cnt[k] = click_cnt[k] + 2'd1;
        t_release[k] = now;
        if (click_cnt[k] >= 2'd2) begin
          fire = 1'b1;
          code = GEST_DOUBLE;
          click_cnt[k] = 2'd0;
        end
      end
    end
    elapsed = now - t_press[k];
    if (lvl_stable[k] && !long_seen[k] && elapsed >= {16'd0, cfg_long}) begin
      long_seen[k] = 1'b1;
      click_cnt[k] = 2'd0;
      fire = 1'b1;
      code = GEST_LONG;
    end
    elapsed = now - t_release[k];
    if (!lvl_stable[k] && click_cnt[k] == 2'd1 && elapsed >= {16'd0, cfg_window}) begin
      fire = 1'b1;
      code = GEST_CLICK;
      click_cnt[k] = 2'd0;
    end
  endtask

  task automatic predict_gestures(input in_item_t s, output int n, output out_item_t res[2]);
    logic       a_held;
    logic       b_held;
    logic       fire;
    logic [1:0] code;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    a_held = cfg_en_a & s.key_a_pressed;
    b_held = cfg_en_b & s.key_b_pressed;
    if (!is_armed) begin
      lvl_raw[0] = a_held;
      lvl_stable[0] = a_held;
      lvl_raw[1] = b_held;
      lvl_stable[1] = b_held;
      click_cnt[0] = 2'd0;
      click_cnt[1] = 2'd0;
      if (a_held || b_held) begin
        quiet_timing = 1'b0;
        quiet_since = '0;
        return;
      end
      if (!quiet_timing) begin
        quiet_timing = 1'b1;
        quiet_since = s.now_ms;
        return;
      end
      if (s.now_ms - quiet_since < {16'd0, cfg_arm}) return;
      t_raw_edge[0] = s.now_ms;
      t_raw_edge[1] = s.now_ms;
      is_armed = 1'b1;
    end
    if (cfg_en_a) begin
      classify_key(0, s.now_ms, s.key_a_pressed, fire, code);
      if (fire) begin
        res[n].action = ACT_A_BASE + {1'b0, code};
        n++;
      end
    end
    if (cfg_en_b) begin
      classify_key(1, s.now_ms, s.key_b_pressed, fire, code);
      if (fire) begin
        res[n].action = ACT_B_BASE + {1'b0, code};
        n++;
      end
    end
    for (int i = 0; i < n; i++) res[i].last = (i == n - 1);
  endtask

  task automatic send_sample(input in_item_t s, input bit typed = 1'b0, input int typed_n = 0,
                             input logic [2:0] typed0 = NO_ACT,
                             input logic [2:0] typed1 = NO_ACT);
    int        n;
    out_item_t res[2];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
    predict_gestures(s, n, res);
    if (typed) begin
      n = typed_n;
      res[0].action = typed0;
      res[0].last = (typed_n == 1);
      res[1].action = typed1;
      res[1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) expected_gestures.push_back(res[i]);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_levels(input logic [31:0] at_ms, input logic a, input logic b);
    in_item_t s;
    s.now_ms = at_ms;
    s.key_a_pressed = a;
    s.key_b_pressed = b;
    send_sample(s);
  endtask

  // Drives a level change, optionally with contact bounce, and holds it for ms.
  task automatic hold_levels(input logic la, input logic lb, input int unsigned ms);
    logic [31:0] t0;
    int unsigned deb;
    deb = 32'(cfg_debounce);
    t0 = t_now;
    send_levels(t0, la, lb);
    if (deb > 1 && $urandom_range(99) < 25) begin
      t0 = t0 + $urandom_range(deb - 1);
      send_levels(t0, hold_a, hold_b);
      t0 = t0 + $urandom_range(deb - 1);
      send_levels(t0, la, lb);
    end
    send_levels(t0 + deb, la, lb);
    if (ms > deb) send_levels(t0 + ms, la, lb);
    hold_a = la;
    hold_b = lb;
    t_now = t0 + ((ms > deb) ? ms : deb);
  endtask

  task automatic play_gesture();
    logic        pa;
    logic        pb;
    int unsigned deb;
    int unsigned lp;
    int unsigned win;
    int unsigned sel;
    deb = 32'(cfg_debounce);
    lp = 32'(cfg_long);
    win = 32'(cfg_window);
    sel = $urandom_range(9);
    pa = (sel < 4) || (sel >= 8);
    pb = (sel >= 4);
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        hold_levels(pa, pb, deb + $urandom_range(15));
        hold_levels(1'b0, 1'b0, win + $urandom_range(20));
      end
      4, 5: begin
        hold_levels(pa, pb, deb + $urandom_range(10));
        hold_levels(1'b0, 1'b0, deb + $urandom_range(10));
        hold_levels(pa, pb, deb + $urandom_range(10));
        hold_levels(1'b0, 1'b0, win + $urandom_range(20));
      end
      6, 7: begin
        hold_levels(pa, pb, lp + $urandom_range(30));
        hold_levels(1'b0, 1'b0, deb + $urandom_range(30));
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(9) == 0) t_now = $urandom();
          else t_now = t_now + $urandom_range(2 * deb + 5);
          hold_a = 1'($urandom_range(1));
          hold_b = 1'($urandom_range(1));
          send_levels(t_now, hold_a, hold_b);
        end
      end
    endcase
  endtask

  task automatic drain_results(input bit settle);
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_gestures.size() != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves psel and penable high so that writes can follow back to back.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] word);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DEBOUNCE:   cfg_debounce = word[15:0];
      REG_LONG_PRESS: cfg_long = word[15:0];
      REG_DBL_WINDOW: cfg_window = word[15:0];
      REG_ARM_REL:    cfg_arm = word[15:0];
      REG_KEY_A_EN:   cfg_en_a = word[0];
      REG_KEY_B_EN:   cfg_en_b = word[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic cfg_check(input logic [2:0] idx, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("register read", int'(prdata), int'(want));
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] deb, input logic [15:0] lp,
                                input logic [15:0] win, input logic [15:0] arm,
                                input logic ena, input logic enb);
    cfg_write(REG_DEBOUNCE, {16'($urandom), deb});
    cfg_write(REG_LONG_PRESS, {16'($urandom), lp});
    cfg_write(REG_DBL_WINDOW, {16'($urandom), win});
    cfg_write(REG_ARM_REL, {16'($urandom), arm});
    cfg_write(REG_KEY_A_EN, {31'($urandom), ena});
    cfg_write(REG_KEY_B_EN, {31'($urandom), enb});
    cfg_write(REG_SPARE, $urandom);
    cfg_check(REG_DEBOUNCE, {16'd0, cfg_debounce});
    cfg_check(REG_LONG_PRESS, {16'd0, cfg_long});
    cfg_check(REG_DBL_WINDOW, {16'd0, cfg_window});
    cfg_check(REG_ARM_REL, {16'd0, cfg_arm});
    cfg_check(REG_KEY_A_EN, {31'd0, cfg_en_a});
    cfg_check(REG_KEY_B_EN, {31'd0, cfg_en_b});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_gestures.size() == 0) begin
        report_mismatch("unexpected action", int'(out_data.action), -1);
      end else begin
        want = expected_gestures.pop_front();
        if (out_data.action !== want.action) begin
          report_mismatch("action", int'(out_data.action), int'(want.action));
        end
        if (out_data.last !== want.last) begin
          report_mismatch("last", int'(out_data.last), int'(want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[dual_button_gesture_detector] ERROR");
      $finish;
    end
  end

  initial begin
    in_item_t    s;
    int unsigned target;
    int unsigned gestures;
    cfg_debounce = DEBOUNCE_RST;
    cfg_long = LONG_PRESS_RST;
    cfg_window = DBL_WINDOW_RST;
    cfg_arm = ARM_REL_RST;
    cfg_en_a = 1'b1;
    cfg_en_b = 1'b1;
    for (int k = 0; k < 2; k++) begin
      lvl_raw[k] = 1'b0;
      lvl_stable[k] = 1'b0;
      long_seen[k] = 1'b0;
      click_cnt[k] = 2'd0;
      t_raw_edge[k] = '0;
      t_press[k] = '0;
      t_release[k] = '0;
    end
    is_armed = 1'b0;
    quiet_timing = 1'b0;
    quiet_since = '0;

    // The release interval may start at time zero. A press while disarmed
    // restarts it, and the arming sample already scans the keys.
    dir_tab = '{
      '{32'd0,    1'b0, 1'b0, 1'b1, 0, NO_ACT,   NO_ACT},
      '{32'd300,  1'b0, 1'b1, 1'b1, 0, NO_ACT,   NO_ACT},
      '{32'd400,  1'b0, 1'b0, 1'b1, 0, NO_ACT,   NO_ACT},
      '{32'd900,  1'b0, 1'b0, 1'b1, 0, NO_ACT,   NO_ACT},
      '{32'd1000, 1'b1, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd1020, 1'b1, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd1100, 1'b0, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd1120, 1'b0, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd1420, 1'b0, 1'b0, 1'b1, 1, A_CLICK,  NO_ACT},
      '{32'd1500, 1'b1, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd1520, 1'b1, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd1550, 1'b0, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd1570, 1'b0, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd1600, 1'b1, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd1620, 1'b1, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd1650, 1'b0, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd1670, 1'b0, 1'b0, 1'b1, 1, A_DOUBLE, NO_ACT},
      '{32'd1700, 1'b0, 1'b1, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd1720, 1'b0, 1'b1, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd2520, 1'b0, 1'b1, 1'b1, 1, B_LONG,   NO_ACT},
      '{32'd2600, 1'b0, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd2620, 1'b0, 1'b0, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd2700, 1'b1, 1'b1, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd2720, 1'b1, 1'b1, 1'b0, 0, NO_ACT,   NO_ACT},
      '{32'd3520, 1'b1, 1'b1, 1'b1, 2, A_LONG,   B_LONG}
    };

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[r]) begin
      s.now_ms = dir_tab[r].at_ms;
      s.key_a_pressed = dir_tab[r].a;
      s.key_b_pressed = dir_tab[r].b;
      send_sample(s, dir_tab[r].typed, dir_tab[r].n, dir_tab[r].act0, dir_tab[r].act1);
    end
    t_now = 32'd3600;
    hold_a = 1'b1;
    hold_b = 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results(1'b1);
      case (ph)
        0: apply_settings(DEBOUNCE_RST, LONG_PRESS_RST, DBL_WINDOW_RST, ARM_REL_RST, 1'b1, 1'b1);
        1: apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
        2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        3: apply_settings(16'($urandom_range(30)), 16'($urandom_range(200)),
                          16'($urandom_range(150)), 16'($urandom_range(65535)), 1'b0, 1'b1);
        4: apply_settings(16'($urandom_range(30)), 16'($urandom_range(200)),
                          16'($urandom_range(150)), 16'($urandom_range(65535)), 1'b1, 1'b0);
        6: apply_settings(16'($urandom_range(30)), 16'($urandom_range(200)),
                          16'($urandom_range(150)), 16'($urandom_range(65535)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
        default: apply_settings(16'($urandom_range(30)), 16'($urandom_range(200)),
                                16'($urandom_range(150)), 16'($urandom_range(65535)),
                                1'b1, 1'b1);
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 88;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 88;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      if (ph == 2) t_now = $urandom();
      if (ph == 5) t_now = 32'hFFFF_FF00;
      target = samples_sent + PHASE_SAMPLES;
      gestures = 0;
      while (samples_sent < target) begin
        play_gesture();
        gestures++;
        if (gestures % 25 == 0) drain_results(1'b0);
      end
    end

    drain_results(1'b1);
    if (mismatches == 0) begin
      $display("[dual_button_gesture_detector] OK");
    end else begin
      $display("[dual_button_gesture_detector] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dbgd_pkg.sv
rtl/dbgd_key.sv
rtl/dbgd_res_fifo.sv
rtl/dual_button_gesture_detector.sv
tb/sv/tb_dual_button_gesture_detector.sv
